// ----- hdl/brl_pkg.sv -----
// Package for the Bresenham line rasteriser: word types, register indexes,
// controller states and the command and status structs.
// No dependencies.
`default_nettype none

package brl_pkg;

    localparam int COORD_W = 6;
    localparam int GLYPH_W = 8;
    localparam int DIM_W   = 7;
    localparam int INDEX_W = 4;

    localparam logic [INDEX_W-1:0] CFG_CANVAS_WIDTH  = 4'd0;
    localparam logic [INDEX_W-1:0] CFG_CANVAS_HEIGHT = 4'd1;
    localparam logic [DIM_W-1:0]   DIM_RESET         = 7'd64;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [GLYPH_W-1:0] glyph;
    } t_line;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [GLYPH_W-1:0] point_glyph;
        logic               inside_res;
        logic               last;
    } t_point;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [DIM_W-1:0]   value;
    } t_cfg;

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_ctrl;

    typedef struct packed {
        logic fin;
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/brl_if.sv -----
// Valid/ready channel interfaces for line requests, plotted points and
// register writes. Depends on brl_pkg.
`default_nettype none

interface brl_line_if;
    logic          valid;
    logic          ready;
    brl_pkg::t_line data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brl_point_if;
    logic           valid;
    logic           ready;
    brl_pkg::t_point data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface brl_cfg_if;
    logic         valid;
    logic         ready;
    brl_pkg::t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/brl_ctrl.sv -----
// Controller of the line rasteriser: idle/draw state machine issuing load
// and step commands to the datapath. Depends on brl_pkg.
`default_nettype none

module brl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_line_valid,
    output logic                o_line_ready,
    output logic                o_point_valid,
    input  wire logic           i_point_ready,
    input  wire brl_pkg::t_stat i_stat,
    output brl_pkg::t_ctrl      o_ctrl
);

    brl_pkg::t_state r_state;
    brl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        logic out_take;
        logic in_take;
        n_state       = r_state;
        o_point_valid = 1'b0;
        o_line_ready  = 1'b0;
        o_ctrl        = '0;
        out_take      = 1'b0;
        in_take       = 1'b0;
        unique case (r_state)
            brl_pkg::ST_IDLE: begin
                o_line_ready = 1'b1;
                in_take      = i_line_valid;
                if (in_take) begin
                    n_state = brl_pkg::ST_DRAW;
                end
            end
            brl_pkg::ST_DRAW: begin
                o_point_valid = 1'b1;
                out_take      = i_point_ready;
                o_line_ready  = out_take && i_stat.fin;
                in_take       = o_line_ready && i_line_valid;
                o_ctrl.step   = out_take && !i_stat.fin;
                if (out_take && i_stat.fin && !in_take) begin
                    n_state = brl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = brl_pkg::ST_IDLE;
            end
        endcase
        o_ctrl.load = in_take;
    end

endmodule

`default_nettype wire

// ----- hdl/brl_datapath.sv -----
// Datapath of the line rasteriser: canvas registers, current point, end
// point and Bresenham error term. Depends on brl_pkg.
`default_nettype none

module brl_datapath #(
    parameter int COORD_SPAN = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire brl_pkg::t_line i_line,
    input  wire logic           i_cfg_we,
    input  wire brl_pkg::t_cfg  i_cfg,
    input  wire brl_pkg::t_ctrl i_ctrl,
    output brl_pkg::t_stat      o_stat,
    output brl_pkg::t_point     o_point
);

    localparam int CW = brl_pkg::COORD_W;
    localparam int EW = CW + 3;
    localparam int WRAP = (COORD_SPAN < 64) ? COORD_SPAN : 64;
    localparam logic [CW:0] WRAP_V = (CW+1)'(WRAP);

    logic [brl_pkg::DIM_W-1:0] r_width;
    logic [brl_pkg::DIM_W-1:0] r_height;
    logic [CW-1:0]             r_x, r_y, r_xe, r_ye;
    logic [CW-1:0]             r_dx;
    logic signed [CW:0]        r_dy;
    logic                      r_sx, r_sy;
    logic signed [EW-1:0]      r_err;
    logic [brl_pkg::GLYPH_W-1:0] r_glyph;

    logic [CW-1:0]        n_x, n_y, n_xe, n_ye, n_dx;
    logic signed [CW:0]   n_dy;
    logic                 n_sx, n_sy;
    logic signed [EW-1:0] n_err;

    function automatic logic [CW-1:0] f_wrap(input logic [CW-1:0] v);
        logic [CW:0] t;
        t = {1'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (t >= WRAP_V) begin
                t = t - WRAP_V;
            end
        end
        return t[CW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= brl_pkg::DIM_RESET;
            r_height <= brl_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg.index)
                brl_pkg::CFG_CANVAS_WIDTH:  r_width  <= i_cfg.value;
                brl_pkg::CFG_CANVAS_HEIGHT: r_height <= i_cfg.value;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [CW-1:0]        sx0, sy0;
        logic signed [EW:0]   e2;
        logic signed [EW-1:0] dx_e, dy_e;
        n_x   = r_x;
        n_y   = r_y;
        n_xe  = r_xe;
        n_ye  = r_ye;
        n_dx  = r_dx;
        n_dy  = r_dy;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_err = r_err;
        sx0   = '0;
        sy0   = '0;
        e2    = '0;
        dx_e  = '0;
        dy_e  = '0;
        if (i_ctrl.load) begin
            sx0  = f_wrap(i_line.start_x);
            sy0  = f_wrap(i_line.start_y);
            n_x  = sx0;
            n_y  = sy0;
            n_xe = f_wrap(i_line.end_x);
            n_ye = f_wrap(i_line.end_y);
            n_sx = sx0 < n_xe;
            n_sy = sy0 < n_ye;
            n_dx = (n_xe >= sx0) ? (n_xe - sx0) : (sx0 - n_xe);
            n_dy = (n_ye >= sy0) ? -$signed({1'b0, n_ye - sy0})
                                 : -$signed({1'b0, sy0 - n_ye});
            n_err = $signed({{(EW-CW){1'b0}}, n_dx}) + EW'(n_dy);
        end else if (i_ctrl.step) begin
            e2   = {r_err, 1'b0};
            dx_e = $signed({{(EW-CW){1'b0}}, r_dx});
            dy_e = EW'(r_dy);
            if (e2 >= (EW+1)'(dy_e)) begin
                n_x = r_sx ? (r_x + 1'b1) : (r_x - 1'b1);
            end
            if (e2 <= (EW+1)'(dx_e)) begin
                n_y = r_sy ? (r_y + 1'b1) : (r_y - 1'b1);
            end
            n_err = r_err + ((e2 >= (EW+1)'(dy_e)) ? dy_e : '0)
                          + ((e2 <= (EW+1)'(dx_e)) ? dx_e : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_xe  <= n_xe;
        r_ye  <= n_ye;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_sx  <= n_sx;
        r_sy  <= n_sy;
        r_err <= n_err;
        if (i_ctrl.load) begin
            r_glyph <= i_line.glyph;
        end
    end

    assign o_stat.fin          = (r_x == r_xe) && (r_y == r_ye);
    assign o_point.point_x     = r_x;
    assign o_point.point_y     = r_y;
    assign o_point.point_glyph = r_glyph;
    assign o_point.inside_res  = ({1'b0, r_x} < r_width) && ({1'b0, r_y} < r_height);
    assign o_point.last        = o_stat.fin;

endmodule

`default_nettype wire

// ----- hdl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasteriser: joins controller and datapath.
// Depends on brl_pkg, brl_if, brl_ctrl and brl_datapath.
//
// Use: a line request word on i_line carries two endpoints and a glyph. The
// block walks the line and sends one point word per pixel on o_point, in
// order from the first endpoint to the second, with last set on the second.
// Coinciding endpoints give a single point with last set.
// i_cfg writes the canvas width (index 0) and height (index 1); other
// indexes are ignored. The write channel is always ready.
// Latency: the first point is valid in the cycle after the request is taken.
// Throughput: max(|dx|,|dy|)+1 points per line, at most 64, one point per
// cycle while ready, set by the single error-term update. A new request is
// taken in the cycle the last point of the previous line is taken.
// A stalled receiver holds the current point and the walk stops until it is
// taken. Reset empties the block and sets both canvas sizes to 64.
`default_nettype none

module bresenham_line_rasterizer #(
    parameter int COORD_SPAN = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    brl_line_if.sink    i_line,
    brl_point_if.source o_point,
    brl_cfg_if.sink     i_cfg
);

    brl_pkg::t_ctrl w_ctrl;
    brl_pkg::t_stat w_stat;

    assign i_cfg.ready = 1'b1;

    brl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_valid  (i_line.valid),
        .o_line_ready  (i_line.ready),
        .o_point_valid (o_point.valid),
        .i_point_ready (o_point.ready),
        .i_stat        (w_stat),
        .o_ctrl        (w_ctrl)
    );

    brl_datapath #(
        .COORD_SPAN (COORD_SPAN)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_line   (i_line.data),
        .i_cfg_we (i_cfg.valid),
        .i_cfg    (i_cfg.data),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat),
        .o_point  (o_point.data)
    );

`ifndef SYNTH
    a_accept_starts_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_line.valid && i_line.ready |=> o_point.valid)
        else $error("accepted line produced no point");

    a_ready_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_line.ready && o_point.valid |-> o_point.ready && o_point.data.last)
        else $error("line taken while a line is still being drawn");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_point.valid)
        else $error("point valid after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point.valid && !o_point.ready |=> o_point.valid && $stable(o_point.data))
        else $error("point word changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_bresenham_line_rasterizer.sv -----
// Testbench for bresenham_line_rasterizer: line request words with a scoreboard that walks each
// line itself, under several canvas sizes and with random stalls on both channels.
// Depends on brl_pkg, brl_if and the rasteriser RTL.
`default_nettype none

module tb_bresenham_line_rasterizer;

    localparam int COORD_SPAN   = 64;
    localparam int PHASES       = 9;
    localparam int PHASE_LINES  = 27;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    class raster_scoreboard;
        logic [brl_pkg::DIM_W-1:0] width_q;
        logic [brl_pkg::DIM_W-1:0] height_q;
        brl_pkg::t_point           points_due[$];
        int                        mismatches;
        int                        points_seen;
        int                        lines_seen;

        function new();
            width_q     = brl_pkg::DIM_RESET;
            height_q    = brl_pkg::DIM_RESET;
            mismatches  = 0;
            points_seen = 0;
            lines_seen  = 0;
        endfunction

        function void write_reg(logic [brl_pkg::INDEX_W-1:0] idx,
                                logic [brl_pkg::DIM_W-1:0] val);
            case (idx)
                brl_pkg::CFG_CANVAS_WIDTH:  width_q = val;
                brl_pkg::CFG_CANVAS_HEIGHT: height_q = val;
                default: ;
            endcase
        endfunction

        // Walks the error-term line and queues one expected point word per pixel.
        function void note_line(brl_pkg::t_line w);
            int              x, y, xe, ye, dx, dy, sx, sy, err, e2;
            bit              fin;
            brl_pkg::t_point p;
            x  = int'(w.start_x) % COORD_SPAN;
            y  = int'(w.start_y) % COORD_SPAN;
            xe = int'(w.end_x) % COORD_SPAN;
            ye = int'(w.end_y) % COORD_SPAN;
            dx = (xe >= x) ? xe - x : x - xe;
            dy = -((ye >= y) ? ye - y : y - ye);
            sx = (x < xe) ? 1 : -1;
            sy = (y < ye) ? 1 : -1;
            err = dx + dy;
            lines_seen++;
            for (int n = 0; n < COORD_SPAN; n++) begin
                fin           = (x == xe) && (y == ye);
                p.point_x     = x[brl_pkg::COORD_W-1:0];
                p.point_y     = y[brl_pkg::COORD_W-1:0];
                p.point_glyph = w.glyph;
                p.inside_res  = (x < int'(width_q)) && (y < int'(height_q));
                p.last        = fin;
                points_due.push_back(p);
                if (fin) break;
                e2 = 2 * err;
                if (e2 >= dy) begin
                    err += dy;
                    x   += sx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    y   += sy;
                end
            end
        endfunction

        function void check_point(brl_pkg::t_point got);
            brl_pkg::t_point want;
            points_seen++;
            if (points_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("point %0d arrived with none expected: x=%0d y=%0d glyph=%02h",
                             points_seen, got.point_x, got.point_y, got.point_glyph);
                return;
            end
            want = points_due.pop_front();
            if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
                got.point_glyph !== want.point_glyph || got.inside_res !== want.inside_res ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("point %0d mismatch: expected x=%0d y=%0d glyph=%02h inside=%0b last=%0b",
                             points_seen, want.point_x, want.point_y, want.point_glyph,
                             want.inside_res, want.last);
                    $display("point %0d mismatch: got x=%0d y=%0d glyph=%02h inside=%0b last=%0b",
                             points_seen, got.point_x, got.point_y, got.point_glyph,
                             got.inside_res, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady = 1'b0;
    int   quiet_cycles = 0;

    raster_scoreboard board = new();

    brl_line_if  line_if ();
    brl_point_if point_if ();
    brl_cfg_if   cfg_if ();

    bresenham_line_rasterizer #(
        .COORD_SPAN(COORD_SPAN)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_line (line_if),
        .o_point(point_if),
        .i_cfg  (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        point_if.ready <= steady || ($urandom_range(99) >= 6);
    end

    // Outputs are sampled on the falling edge before the edge that takes them. A point word
    // that nothing was waiting for does not count as progress.
    always @(negedge i_clk) begin
        bit wanted;
        wanted = board.points_due.size() != 0;
        if (i_rst_n && point_if.valid && point_if.ready)
            board.check_point(point_if.data);
        if ((line_if.valid && line_if.ready) ||
            (point_if.valid && point_if.ready && wanted) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timed out after %0d cycles without a handshake", quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic brl_pkg::t_line line_word(int sx, int sy, int ex, int ey, int g);
        brl_pkg::t_line w;
        w.start_x = sx[brl_pkg::COORD_W-1:0];
        w.start_y = sy[brl_pkg::COORD_W-1:0];
        w.end_x   = ex[brl_pkg::COORD_W-1:0];
        w.end_y   = ey[brl_pkg::COORD_W-1:0];
        w.glyph   = g[brl_pkg::GLYPH_W-1:0];
        return w;
    endfunction

    function automatic brl_pkg::t_line pick_line();
        int sx, sy, ex, ey;
        sx = $urandom_range(63);
        sy = $urandom_range(63);
        ex = $urandom_range(63);
        ey = $urandom_range(63);
        case ($urandom_range(9))
            0: begin
                ex = sx;
                ey = sy;
            end
            1: ey = sy;
            2: ex = sx;
            3, 4: begin
                ex = sx + int'($urandom_range(6)) - 3;
                ey = sy + int'($urandom_range(6)) - 3;
                ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
                ey = (ey < 0) ? 0 : (ey > 63) ? 63 : ey;
            end
            default: ;
        endcase
        return line_word(sx, sy, ex, ey, $urandom_range(255));
    endfunction

    task automatic send_line(input brl_pkg::t_line w);
        bit took;
        while (!steady && $urandom_range(99) < 6) begin
            line_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        line_if.valid <= 1'b1;
        line_if.data  <= w;
        do begin
            @(negedge i_clk);
            took = line_if.ready;
            @(posedge i_clk);
        end while (!took);
        board.note_line(w);
    endtask

    task automatic write_reg(input logic [brl_pkg::INDEX_W-1:0] idx,
                             input logic [brl_pkg::DIM_W-1:0] val);
        bit took;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= {idx, val};
        do begin
            @(negedge i_clk);
            took = cfg_if.ready;
            @(posedge i_clk);
        end while (!took);
        board.write_reg(idx, val);
    endtask

    task automatic drain();
        while (board.points_due.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        logic [brl_pkg::DIM_W-1:0] w_dim, h_dim;
        int                        settings;
        settings       = 1;
        i_rst_n        = 1'b0;
        line_if.valid  = 1'b0;
        line_if.data   = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        point_if.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_line(line_word(0, 0, 0, 0, 8'h00));
        send_line(line_word(63, 63, 63, 63, 8'hff));
        send_line(line_word(0, 0, 63, 63, 8'ha5));
        send_line(line_word(63, 63, 0, 0, 8'h5a));
        send_line(line_word(63, 0, 0, 63, 8'h01));
        send_line(line_word(0, 63, 63, 0, 8'h80));
        send_line(line_word(0, 10, 63, 10, 8'h2a));
        send_line(line_word(63, 20, 0, 20, 8'h7f));
        send_line(line_word(5, 0, 5, 63, 8'hfe));
        send_line(line_word(40, 63, 40, 0, 8'h23));
        send_line(line_word(0, 0, 63, 1, 8'h55));
        send_line(line_word(0, 0, 1, 63, 8'haa));
        send_line(line_word(10, 10, 13, 20, 8'h40));
        send_line(line_word(20, 30, 11, 27, 8'h2e));
        send_line(line_word(1, 2, 2, 1, 8'h3c));
        line_if.valid <= 1'b0;

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    w_dim = '0;
                    h_dim = '0;
                end
                1: begin
                    w_dim = '1;
                    h_dim = '1;
                end
                2: begin
                    w_dim = 7'd1;
                    h_dim = brl_pkg::DIM_RESET;
                end
                3: begin
                    w_dim = brl_pkg::DIM_RESET;
                    h_dim = 7'd1;
                end
                4: begin
                    w_dim = 7'd33;
                    h_dim = 7'd17;
                end
                5: begin
                    w_dim = '1;
                    h_dim = '0;
                end
                default: begin
                    w_dim = brl_pkg::DIM_W'($urandom_range(127));
                    h_dim = brl_pkg::DIM_W'($urandom_range(127));
                end
            endcase
            write_reg(brl_pkg::CFG_CANVAS_WIDTH, w_dim);
            write_reg(brl_pkg::INDEX_W'($urandom_range(15, 2)),
                      brl_pkg::DIM_W'($urandom_range(127)));
            write_reg(brl_pkg::CFG_CANVAS_HEIGHT, h_dim);
            cfg_if.valid <= 1'b0;
            settings++;
            steady = (phase == 4);
            for (int k = 0; k < PHASE_LINES; k++)
                send_line(pick_line());
            line_if.valid <= 1'b0;
            steady = 1'b0;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Drew %0d lines giving %0d points under %0d canvas sizes, %0d mismatches.",
                 board.lines_seen, board.points_seen, settings, board.mismatches);
        if (board.mismatches == 0 && board.points_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d points still outstanding", board.points_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
